FILE: rtl/hsl2rgb_pkg.sv
// Shared types, constants and helpers for the HSL to RGB converter.
package hsl2rgb_pkg;

  localparam int unsigned CompW  = 8;
  localparam int unsigned LevelW = 9;
  localparam int unsigned ProdW  = 16;
  localparam int unsigned NumCh  = 3;

  localparam int unsigned ChRed   = 0;
  localparam int unsigned ChGreen = 1;
  localparam int unsigned ChBlue  = 2;

  localparam logic [LevelW-1:0] FullTurn  = 9'd256;
  localparam logic [LevelW-1:0] ThirdTurn = 9'd85;
  localparam logic [LevelW-1:0] RiseEnd   = 9'd42;
  localparam logic [LevelW-1:0] TopEnd    = 9'd127;
  localparam logic [LevelW-1:0] FallEnd   = 9'd170;
  localparam logic [LevelW-1:0] RampGain  = 9'd6;
  localparam logic [CompW-1:0]  CompMax   = 8'd255;

  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_TOP,
    SEG_FALL,
    SEG_FLOOR
  } seg_e;

  typedef logic [LevelW-1:0] pos_t;

  typedef struct packed {
    logic              grey;
    logic [CompW-1:0]  lightness;
    logic [LevelW-1:0] hi;
    logic [CompW-1:0]  lo;
    logic [LevelW-1:0] span;
  } level_t;

  function automatic seg_e seg_of(pos_t t);
    seg_e seg;
    if (t <= RiseEnd) begin
      seg = SEG_RISE;
    end else if (t <= TopEnd) begin
      seg = SEG_TOP;
    end else if (t <= FallEnd) begin
      seg = SEG_FALL;
    end else begin
      seg = SEG_FLOOR;
    end
    return seg;
  endfunction

endpackage

FILE: rtl/hsl_to_rgb_converter.sv
// Top level of the four-stage HSL to RGB pixel converter.
// Throughput: one pixel per cycle, busy stays low; each channel uses one 9x8 multiplier stage.
// Results appear for one cycle under done_o and cannot be held off.
// Reset clears only the valid bits of the pipeline; data registers are not reset.
module hsl_to_rgb_converter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] hue_i,
  input  logic [7:0] saturation_i,
  input  logic [7:0] lightness_i,
  output logic       done_o,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o
);
  import hsl2rgb_pkg::*;

  logic       accept;
  logic       v2;
  level_t     level;
  pos_t       pos [NumCh];
  logic [7:0] value [NumCh];
  logic       v3_q, v4_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  hsl2rgb_levels u_levels (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (accept),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .lightness_i  (lightness_i),
    .valid_o      (v2),
    .level_o      (level),
    .pos_o        (pos)
  );

  for (genvar c = 0; c < NumCh; c++) begin : g_ch
    hsl2rgb_channel u_channel (
      .clk_i   (clk_i),
      .level_i (level),
      .pos_i   (pos[c]),
      .value_o (value[c])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v3_q <= v2;
      v4_q <= v3_q;
    end
  end

  assign done_o  = v4_q;
  assign red_o   = value[ChRed];
  assign green_o = value[ChGreen];
  assign blue_o  = value[ChBlue];

  a_beat_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##4 done_o)
    else $error("accepted beat did not produce a result four cycles later");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 4))
    else $error("result strobe without a matching accepted beat");

  a_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && saturation_i == 8'd0) |-> ##4
      (red_o == $past(lightness_i, 4) && green_o == $past(lightness_i, 4) &&
       blue_o == $past(lightness_i, 4)))
    else $error("zero saturation did not give grey at the lightness level");

endmodule

FILE: rtl/hsl2rgb_levels.sv
// First two pipeline stages: lightness times saturation, then levels and hue positions.
module hsl2rgb_levels (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [7:0]            hue_i,
  input  logic [7:0]            saturation_i,
  input  logic [7:0]            lightness_i,
  output logic                  valid_o,
  output hsl2rgb_pkg::level_t   level_o,
  output hsl2rgb_pkg::pos_t     pos_o [hsl2rgb_pkg::NumCh]
);
  import hsl2rgb_pkg::*;

  logic             v1_q;
  logic [ProdW-1:0] ls_q;
  logic [CompW-1:0] hue_q, sat_q, light_q;

  logic             v2_q;
  level_t           level_q, level_d;
  pos_t             pos_q [NumCh];
  pos_t             pos_d [NumCh];

  logic [9:0]       l_ext, s_ext, ls_hi, hi_w, lo_w;
  pos_t             hue_ext, red_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ls_q    <= ProdW'(lightness_i * saturation_i);
    hue_q   <= hue_i;
    sat_q   <= saturation_i;
    light_q <= lightness_i;
    level_q <= level_d;
    pos_q   <= pos_d;
  end

  always_comb begin
    l_ext = {2'b00, light_q};
    s_ext = {2'b00, sat_q};
    ls_hi = {2'b00, ls_q[ProdW-1:CompW]};
    // Below the midpoint the high level is L*(1+S), from the midpoint up it is L+S-L*S.
    if (!light_q[CompW-1]) begin
      hi_w = l_ext + ls_hi;
    end else begin
      hi_w = l_ext + s_ext - ls_hi;
    end
    lo_w = (l_ext << 1) - hi_w;

    level_d.grey      = (sat_q == '0);
    level_d.lightness = light_q;
    level_d.hi        = hi_w[LevelW-1:0];
    level_d.lo        = lo_w[CompW-1:0];
    level_d.span      = LevelW'(hi_w - lo_w);

    hue_ext = {1'b0, hue_q};
    red_raw = hue_ext + ThirdTurn;
    // A red position of exactly a full turn stays put and lands on the floor.
    pos_d[ChRed]   = (red_raw > FullTurn) ? (red_raw - FullTurn) : red_raw;
    pos_d[ChGreen] = hue_ext;
    pos_d[ChBlue]  = (hue_ext < ThirdTurn) ? (hue_ext + (FullTurn - ThirdTurn))
                                           : (hue_ext - ThirdTurn);
  end

  assign valid_o = v2_q;
  assign level_o = level_q;
  assign pos_o   = pos_q;

endmodule

FILE: rtl/hsl2rgb_channel.sv
// Last two pipeline stages of one color channel: ramp multiply, then segment select and clamp.
module hsl2rgb_channel (
  input  logic                clk_i,
  input  hsl2rgb_pkg::level_t level_i,
  input  hsl2rgb_pkg::pos_t   pos_i,
  output logic [7:0]          value_o
);
  import hsl2rgb_pkg::*;

  seg_e              seg_d, seg_q;
  pos_t              ramp_pos;
  logic [CompW-1:0]  gain;
  logic [ProdW-1:0]  prod;
  logic [CompW-1:0]  ramp_q;
  logic [CompW-1:0]  lo_q, light_q;
  logic [LevelW-1:0] hi_q;
  logic              grey_q;

  logic [LevelW-1:0] sum, lvl;
  logic [CompW-1:0]  value_d, value_q;

  always_comb begin
    seg_d    = seg_of(pos_i);
    // The falling ramp measures its distance back from the end of the ramp.
    ramp_pos = (seg_d == SEG_FALL) ? (FallEnd - pos_i) : pos_i;
    gain     = CompW'(ramp_pos * RampGain);
    prod     = ProdW'(level_i.span * gain);
  end

  always_ff @(posedge clk_i) begin
    seg_q   <= seg_d;
    ramp_q  <= prod[ProdW-1:CompW];
    lo_q    <= level_i.lo;
    hi_q    <= level_i.hi;
    light_q <= level_i.lightness;
    grey_q  <= level_i.grey;
    value_q <= value_d;
  end

  always_comb begin
    sum = {1'b0, lo_q} + {1'b0, ramp_q};
    unique case (seg_q)
      SEG_RISE:  lvl = sum;
      SEG_TOP:   lvl = hi_q;
      SEG_FALL:  lvl = sum;
      SEG_FLOOR: lvl = {1'b0, lo_q};
      default:   lvl = {1'b0, lo_q};
    endcase
    if (grey_q) begin
      value_d = light_q;
    end else if (lvl[LevelW-1]) begin
      value_d = CompMax;
    end else begin
      value_d = lvl[CompW-1:0];
    end
  end

  assign value_o = value_q;

endmodule
